// ===== src/infix_to_postfix_converter_core_macros.svh =====
// Assertion macros for the converter. Each macro takes a label, the clock,
// the active-low reset, an antecedent and a consequent.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ICP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("icp assertion failed");
`define ICP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("icp assertion failed");
`else
`define ICP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ICP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/icp_pkg.sv =====
package icp_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_ADD    = 8'h2B;
	localparam logic [7:0] CH_SUB    = 8'h2D;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_DIV    = 3'd3,
		OP_LPAREN = 3'd4
	} op_code_t;

	typedef enum logic [2:0] {
		K_DIGIT,
		K_OP,
		K_LPAREN,
		K_RPAREN,
		K_OTHER
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_OPPOP,
		B_RPOP,
		B_TAIL,
		B_FLUSH,
		B_END
	} back_state_t;

	typedef struct packed {
		kind_t      kind;
		op_code_t   code;
		logic [7:0] ch;
		logic       eoe;
	} q_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             send_done;
	} back_stat_t;

	function automatic logic rank_high(op_code_t c);
		return (c == OP_MUL) || (c == OP_DIV);
	endfunction

	function automatic logic [7:0] code_char(op_code_t c);
		logic [7:0] r;
		unique case (c)
			OP_ADD:  r = CH_ADD;
			OP_SUB:  r = CH_SUB;
			OP_MUL:  r = CH_MUL;
			OP_DIV:  r = CH_DIV;
			default: r = CH_LPAREN;
		endcase
		return r;
	endfunction

endpackage

// ===== src/icp_if.sv =====
interface icp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_expression;

	modport source (output valid, output in_char, output end_of_expression, input ready);
	modport sink (input valid, input in_char, input end_of_expression, output ready);
endinterface

interface icp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_run;
	logic       expression_done;
	logic       stack_overflow;

	modport source (output valid, output out_char, output last_of_run,
		output expression_done, output stack_overflow, input ready);
	modport sink (input valid, input out_char, input last_of_run,
		input expression_done, input stack_overflow, output ready);
endinterface

// ===== src/icp_front.sv =====
module icp_front import icp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	icp_in_if.sink  in_ch,
	output q_item_t q_head,
	output logic    q_valid,
	input  logic    q_pop
);

	q_item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	q_item_t             item;
	logic                push;

	always_comb begin
		item.ch   = in_ch.in_char;
		item.eoe  = in_ch.end_of_expression;
		item.code = OP_ADD;
		item.kind = K_OTHER;
		if (in_ch.in_char >= CH_ZERO && in_ch.in_char <= CH_NINE) begin
			item.kind = K_DIGIT;
		end else begin
			unique case (in_ch.in_char)
				CH_ADD: begin
					item.kind = K_OP;
					item.code = OP_ADD;
				end
				CH_SUB: begin
					item.kind = K_OP;
					item.code = OP_SUB;
				end
				CH_MUL: begin
					item.kind = K_OP;
					item.code = OP_MUL;
				end
				CH_DIV: begin
					item.kind = K_OP;
					item.code = OP_DIV;
				end
				CH_LPAREN: begin
					item.kind = K_LPAREN;
					item.code = OP_LPAREN;
				end
				CH_RPAREN: item.kind = K_RPAREN;
				default:   item.kind = K_OTHER;
			endcase
		end
	end

	assign in_ch.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/icp_back.sv =====
module icp_back import icp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_item_t    q_head,
	input  logic       q_valid,
	output logic       q_pop,
	icp_out_if.source  out_ch,
	output back_stat_t stat
);

	back_state_t      state_q, state_d;
	q_item_t          item_q, item_d;
	op_code_t         stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] cnt_m1;
	op_code_t         top;
	logic             run_q, run_d;
	logic             ovf_q, ovf_d;
	logic             hold_v_q, hold_v_d;
	logic [7:0]       hold_ch_q, hold_ch_d;
	logic             out_v_q, out_v_d;
	logic [7:0]       out_ch_q;
	logic             out_last_q, out_done_q, out_ovf_q;

	logic             slot_free, can_gen;
	logic             gen;
	logic [7:0]       gen_ch;
	logic             do_push;
	op_code_t         push_code;
	logic             send, send_last, send_done;
	logic             stack_we;

	assign cnt_m1    = count_q - 1'b1;
	assign top       = stack_q[cnt_m1[IDX_W-1:0]];
	assign slot_free = !out_v_q || out_ch.ready;
	assign can_gen   = !hold_v_q || slot_free;

	always_comb begin
		state_d   = state_q;
		item_d    = item_q;
		count_d   = count_q;
		run_d     = run_q;
		ovf_d     = ovf_q;
		hold_v_d  = hold_v_q;
		hold_ch_d = hold_ch_q;
		q_pop     = 1'b0;
		gen       = 1'b0;
		gen_ch    = CH_SPACE;
		do_push   = 1'b0;
		push_code = item_q.code;
		send      = 1'b0;
		send_last = 1'b0;
		send_done = 1'b0;
		stack_we  = 1'b0;

		unique case (state_q)
			B_IDLE: begin
				// The hold register is always empty here, so the leading result never stalls.
				if (q_valid) begin
					q_pop  = 1'b1;
					item_d = q_head;
					if (q_head.kind == K_DIGIT) begin
						gen     = 1'b1;
						gen_ch  = q_head.ch;
						run_d   = 1'b1;
						state_d = q_head.eoe ? B_TAIL : B_END;
					end else begin
						if (run_q) begin
							gen   = 1'b1;
							run_d = 1'b0;
						end
						unique case (q_head.kind)
							K_OP:     state_d = B_OPPOP;
							K_RPAREN: state_d = B_RPOP;
							K_LPAREN: begin
								do_push   = 1'b1;
								push_code = OP_LPAREN;
								state_d   = q_head.eoe ? B_FLUSH : B_END;
							end
							default:  state_d = q_head.eoe ? B_FLUSH : B_END;
						endcase
					end
				end
			end
			B_OPPOP: begin
				if (count_q != '0 && top != OP_LPAREN &&
						(rank_high(top) || !rank_high(item_q.code))) begin
					if (can_gen) begin
						gen     = 1'b1;
						gen_ch  = code_char(top);
						count_d = cnt_m1;
					end
				end else begin
					do_push = 1'b1;
					state_d = item_q.eoe ? B_FLUSH : B_END;
				end
			end
			B_RPOP: begin
				if (count_q == '0) begin
					state_d = item_q.eoe ? B_FLUSH : B_END;
				end else if (top == OP_LPAREN) begin
					count_d = cnt_m1;
					state_d = item_q.eoe ? B_FLUSH : B_END;
				end else if (can_gen) begin
					gen     = 1'b1;
					gen_ch  = code_char(top);
					count_d = cnt_m1;
				end
			end
			B_TAIL: begin
				if (can_gen) begin
					gen     = 1'b1;
					run_d   = 1'b0;
					state_d = B_FLUSH;
				end
			end
			B_FLUSH: begin
				if (count_q == '0) begin
					state_d = B_END;
				end else if (can_gen) begin
					gen     = 1'b1;
					gen_ch  = code_char(top);
					count_d = cnt_m1;
				end
			end
			B_END: begin
				if (!hold_v_q || slot_free) begin
					if (hold_v_q) begin
						send      = 1'b1;
						send_last = 1'b1;
						send_done = item_q.eoe;
						hold_v_d  = 1'b0;
					end
					if (item_q.eoe) begin
						ovf_d = 1'b0;
					end
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase

		// A push onto a full stack is dropped; no pop has happened in this
		// transaction then, so every result of it is still unsent.
		if (do_push) begin
			if (count_q == CNT_W'(STACK_DEPTH)) begin
				ovf_d = 1'b1;
			end else begin
				stack_we = 1'b1;
				count_d  = count_q + 1'b1;
			end
		end

		// Each new result goes to the hold register; the one it displaces is
		// known not to be the last of its transaction.
		if (gen) begin
			if (hold_v_q) begin
				send = 1'b1;
			end
			hold_v_d  = 1'b1;
			hold_ch_d = gen_ch;
		end
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_q[count_q[IDX_W-1:0]] <= push_code;
		end
		item_q    <= item_d;
		hold_ch_q <= hold_ch_d;
		if (send) begin
			out_ch_q   <= hold_ch_q;
			out_last_q <= send_last;
			out_done_q <= send_done;
			out_ovf_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			count_q  <= '0;
			run_q    <= 1'b0;
			ovf_q    <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			run_q    <= run_d;
			ovf_q    <= ovf_d;
			hold_v_q <= hold_v_d;
			out_v_q  <= out_v_d;
		end
	end

	always_comb begin
		if (send) begin
			out_v_d = 1'b1;
		end else if (out_ch.ready) begin
			out_v_d = 1'b0;
		end else begin
			out_v_d = out_v_q;
		end
	end

	assign out_ch.valid           = out_v_q;
	assign out_ch.out_char        = out_ch_q;
	assign out_ch.last_of_run     = out_last_q;
	assign out_ch.expression_done = out_done_q;
	assign out_ch.stack_overflow  = out_ovf_q;

	assign stat.count     = count_q;
	assign stat.send_done = send && send_done;

endmodule

// ===== src/infix_to_postfix_converter_core.sv =====
// Infix to postfix converter, shunting-yard rule, one ASCII character per
// input transaction and one postfix character per output transaction. The
// front classifies each character into a two-entry queue; the back sequencer
// works on one queued character at a time and produces at most one result
// per cycle, keeping a 16-entry operator stack in flip-flops. A digit is
// passed on, a '(' is pushed, an operator first pops each operator of
// equal or higher rank and is then pushed, a ')' emits the operators above
// its '(' and drops that, and an end-of-expression character then flushes
// the stack, after the closing space when it is a digit. Results leave
// through a registered output stage behind a one-result hold register, so
// a stalled output only halts the sequencer once both of them are
// occupied. The stack_overflow flag is sticky over an expression and is
// cleared after its final character.
`include "infix_to_postfix_converter_core_macros.svh"

module infix_to_postfix_converter_core import icp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	icp_in_if.sink    in_ch,
	icp_out_if.source out_ch
);

	q_item_t    q_head;
	logic       q_valid;
	logic       q_pop;
	back_stat_t stat;

	icp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	icp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.out_ch  (out_ch),
		.stat    (stat)
	);

	// The sequencer only takes a character that the queue actually holds.
	`ICP_ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, q_valid)
	// An accepted character is in the queue in the following cycle.
	`ICP_ASSERT_NEXT(a_accept_queued, clk, arst_n, in_ch.valid && in_ch.ready, q_valid)
	// The final result of an expression leaves behind an empty stack.
	`ICP_ASSERT_IMP(a_done_empty, clk, arst_n, stat.send_done, stat.count == '0)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import icp_pkg::*;

	localparam int ITEM_TARGET = 330;
	localparam int QUIET_TAIL  = 40;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       done;
		logic       ovf;
	} postfix_char_t;

	// Shunting-yard predictor with its own operator stack; every accepted input
	// transaction appends the postfix characters it should produce.
	class postfix_scoreboard;
		op_code_t      op_stack[STACK_DEPTH];
		int unsigned   stack_fill;
		bit            digit_open;
		bit            overflow_flag;
		postfix_char_t burst[$];
		postfix_char_t postfix_due[$];
		int unsigned   mismatches;
		int unsigned   checked;
		int unsigned   expressions;
		int unsigned   overflowed;

		function void put(logic [7:0] ch);
			postfix_char_t r;
			r = '0;
			r.ch = ch;
			burst.push_back(r);
		endfunction

		function void push_op(op_code_t c);
			if (stack_fill < STACK_DEPTH) begin
				op_stack[stack_fill] = c;
				stack_fill++;
			end else begin
				overflow_flag = 1'b1;
			end
		endfunction

		function logic [7:0] symbol(op_code_t c);
			case (c)
				OP_ADD:  return CH_ADD;
				OP_SUB:  return CH_SUB;
				OP_MUL:  return CH_MUL;
				OP_DIV:  return CH_DIV;
				default: return CH_LPAREN;
			endcase
		endfunction

		function bit tight(op_code_t c);
			return (c == OP_MUL) || (c == OP_DIV);
		endfunction

		function void convert_char(logic [7:0] ch, logic eoe);
			op_code_t code;
			op_code_t top;
			bit       is_op;
			int       n;
			burst.delete();
			is_op = 1'b1;
			code = OP_ADD;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				put(ch);
				digit_open = 1'b1;
			end else begin
				if (digit_open) begin
					put(CH_SPACE);
					digit_open = 1'b0;
				end
				case (ch)
					CH_ADD:  code = OP_ADD;
					CH_SUB:  code = OP_SUB;
					CH_MUL:  code = OP_MUL;
					CH_DIV:  code = OP_DIV;
					default: is_op = 1'b0;
				endcase
				if (is_op) begin
					while (stack_fill > 0) begin
						top = op_stack[stack_fill - 1];
						if (top == OP_LPAREN || (tight(top) < tight(code)))
							break;
						stack_fill--;
						put(symbol(top));
					end
					push_op(code);
				end else if (ch == CH_LPAREN) begin
					push_op(OP_LPAREN);
				end else if (ch == CH_RPAREN) begin
					// An unmatched closing bracket drains the whole stack.
					while (stack_fill > 0) begin
						stack_fill--;
						top = op_stack[stack_fill];
						if (top == OP_LPAREN)
							break;
						put(symbol(top));
					end
				end
			end
			if (eoe) begin
				if (digit_open) begin
					put(CH_SPACE);
					digit_open = 1'b0;
				end
				while (stack_fill > 0) begin
					stack_fill--;
					put(symbol(op_stack[stack_fill]));
				end
			end
			n = burst.size();
			for (int i = 0; i < n; i++)
				burst[i].ovf = overflow_flag;
			if (n != 0) begin
				burst[n - 1].last = 1'b1;
				burst[n - 1].done = eoe;
			end
			if (eoe) begin
				expressions++;
				if (overflow_flag)
					overflowed++;
				overflow_flag = 1'b0;
			end
			for (int i = 0; i < n; i++)
				postfix_due.push_back(burst[i]);
		endfunction

		function void check_postfix(postfix_char_t got);
			postfix_char_t want;
			if (postfix_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output, expected nothing, %s",
					$time, $sformatf("got char=%h last=%b done=%b ovf=%b",
					got.ch, got.last, got.done, got.ovf));
				return;
			end
			want = postfix_due.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				$display("%0t: expected char=%h last=%b done=%b ovf=%b, %s",
					$time, want.ch, want.last, want.done, want.ovf,
					$sformatf("got char=%h last=%b done=%b ovf=%b",
					got.ch, got.last, got.done, got.ovf));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;
	int   stall_left = 0;
	int   cycle_count = 0;
	int   chars_sent = 0;
	bit   src_gaps = 1'b0;
	bit   sink_gaps = 1'b0;
	bit   mid_pause_done = 1'b0;

	postfix_scoreboard sb;

	icp_in_if  in_ch();
	icp_out_if out_ch();

	infix_to_postfix_converter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	assign out_ch.ready = sink_ready;

	// The receiver stalls in bursts of random length while stalls are enabled.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (sink_gaps && $urandom_range(0, 6) == 0) begin
			sink_ready <= 1'b0;
			stall_left <= $urandom_range(0, 17);
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// The input transaction is noted before the output is checked, so a result
	// could never overtake its own prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.convert_char(in_ch.in_char, in_ch.end_of_expression);
			if (out_ch.valid && out_ch.ready)
				sb.check_postfix({out_ch.out_char, out_ch.last_of_run,
					out_ch.expression_done, out_ch.stack_overflow});
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, sb.postfix_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] random_op();
		case ($urandom_range(0, 3))
			0:       return CH_ADD;
			1:       return CH_SUB;
			2:       return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic eoe);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_char <= ch;
		in_ch.end_of_expression <= eoe;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.postfix_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_expression();
		logic [7:0] text[$];
		int         mode;
		int         terms;
		int         depth;
		int         n;
		mode = $urandom_range(0, 19);
		depth = 0;
		if (mode < 14) begin
			terms = $urandom_range(1, 7);
			for (int k = 0; k < terms; k++) begin
				if (k != 0)
					text.push_back(random_op());
				while (depth < 20 && $urandom_range(0, 3) == 0) begin
					text.push_back(CH_LPAREN);
					depth++;
				end
				n = $urandom_range(1, 3);
				repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 7) == 0)
					text.push_back(CH_SPACE);
				while (depth > 0 && $urandom_range(0, 2) == 0) begin
					text.push_back(CH_RPAREN);
					depth--;
				end
			end
			// Some expressions leave brackets open for the final flush.
			if ($urandom_range(0, 3) != 0)
				repeat (depth) text.push_back(CH_RPAREN);
		end else if (mode < 16) begin
			// Nesting deep enough to fill the operator stack.
			n = $urandom_range(12, 20);
			repeat (n) begin
				text.push_back(CH_LPAREN);
				if ($urandom_range(0, 2) == 0) begin
					text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					text.push_back(random_op());
				end
			end
			text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			repeat ($urandom_range(0, n)) text.push_back(CH_RPAREN);
		end else if (mode < 18) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				case ($urandom_range(0, 7))
					0, 1, 2: text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					3:       text.push_back(random_op());
					4:       text.push_back(CH_LPAREN);
					5:       text.push_back(CH_RPAREN);
					6:       text.push_back(CH_SPACE);
					default: text.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) text.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 5) == 0)
			text.push_back(8'($urandom_range(0, 255)));
		for (int k = 0; k < text.size(); k++)
			send_char(text[k], k == text.size() - 1);
	endtask

	initial begin
		sb = new();
		in_ch.valid = 1'b0;
		in_ch.in_char = '0;
		in_ch.end_of_expression = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		// Digit extremes, a space, an unmatched closing bracket and a NUL end.
		send_char(CH_NINE, 1'b0);
		send_char(CH_SPACE, 1'b0);
		send_char(CH_SUB, 1'b0);
		send_char(CH_ZERO, 1'b0);
		send_char(CH_MUL, 1'b0);
		send_char(CH_RPAREN, 1'b0);
		send_char(8'h00, 1'b1);
		// Fill the stack, drop a push, then flush leftover brackets on 0xFF.
		repeat (15) send_char(CH_LPAREN, 1'b0);
		send_char(CH_ADD, 1'b0);
		send_char(CH_DIV, 1'b0);
		send_char(CH_RPAREN, 1'b0);
		send_char(8'hFF, 1'b1);
		hold_until_drained();

		while (chars_sent < ITEM_TARGET) begin
			if (chars_sent >= ITEM_TARGET - QUIET_TAIL) begin
				src_gaps = 1'b0;
				sink_gaps = 1'b0;
			end else begin
				src_gaps = ($urandom_range(0, 2) != 0);
				sink_gaps = ($urandom_range(0, 2) != 0);
			end
			if (!mid_pause_done && chars_sent >= ITEM_TARGET / 2) begin
				hold_until_drained();
				mid_pause_done = 1'b1;
			end
			send_expression();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.postfix_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Converted %0d characters over %0d expressions, %0d of them %s",
			chars_sent, sb.expressions, sb.overflowed, "overflowing the stack.");
		$display("Checked %0d postfix characters, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
